### rtl/hdrtm_pkg.sv
package hdrtm_pkg;

  // register indexes on the configuration port
  localparam logic [0:0] CFG_EXPOSURE = 1'd0;
  localparam logic [0:0] CFG_GAMMA    = 1'd1;

  // register reset values
  localparam logic [15:0] EXPOSURE_RST = 16'd6554;  // 1.6 in Q4.12
  localparam logic [15:0] GAMMA_RST    = 16'd7447;  // 1/2.2 in Q2.14

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // fixed-point constants, Q.32
  localparam logic [31:0] LN2_Q     = 32'hB17217F7;
  localparam logic [30:0] LOG2E_LO  = 31'h71547652;  // log2(e) minus its integer one
  localparam int          EXP_TERMS = 12;
  localparam int          FRAC_BITS = 32;

  // floor(p / k) for 32-bit p as (p * DIV_M[k]) >> DIV_S[k]
  localparam logic [32:0] DIV_M [13] = '{
    33'd0,
    33'd0,
    33'(((64'd1 << 33) + 64'd1) / 64'd2),
    33'(((64'd1 << 34) + 64'd2) / 64'd3),
    33'(((64'd1 << 34) + 64'd3) / 64'd4),
    33'(((64'd1 << 35) + 64'd4) / 64'd5),
    33'(((64'd1 << 35) + 64'd5) / 64'd6),
    33'(((64'd1 << 35) + 64'd6) / 64'd7),
    33'(((64'd1 << 35) + 64'd7) / 64'd8),
    33'(((64'd1 << 36) + 64'd8) / 64'd9),
    33'(((64'd1 << 36) + 64'd9) / 64'd10),
    33'(((64'd1 << 36) + 64'd10) / 64'd11),
    33'(((64'd1 << 36) + 64'd11) / 64'd12)
  };
  localparam logic [5:0] DIV_S [13] = '{
    6'd32, 6'd32, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35,
    6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd36
  };

  // pipeline depths
  localparam int POW2_LAT = 2 * EXP_TERMS;
  localparam int LOG2_LAT = 2 + FRAC_BITS;
  localparam int LANE_LAT = 4 + 2 * POW2_LAT + LOG2_LAT + 4;

  // how the power stage result is formed
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_ONE  = 2'd1,
    MODE_CALC = 2'd2
  } r_mode_t;

endpackage

### rtl/hdrtm_pix_in_if.sv
interface hdrtm_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_half;
  logic [15:0] green_half;
  logic [15:0] blue_half;

  modport source(output valid, output red_half, output green_half, output blue_half,
                 input ready);
  modport sink(input valid, input red_half, input green_half, input blue_half,
               output ready);
endinterface

### rtl/hdrtm_pix_out_if.sv
interface hdrtm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;

  modport source(output valid, output out_blue, output out_green, output out_red,
                 output out_alpha, input ready);
  modport sink(input valid, input out_blue, input out_green, input out_red,
               input out_alpha, output ready);
endinterface

### rtl/hdrtm_pow2.sv
module hdrtm_pow2 #(
  parameter int W  = 38,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  w_i,
  input  logic [TW-1:0] tag_i,
  output logic [32:0]   res_o,
  output logic [TW-1:0] tag_o
);

  localparam int NS = hdrtm_pkg::EXP_TERMS - 1;

  // range reduction: n = integer part, u = frac * ln2
  logic [W-33:0] n_full;
  logic [63:0]   fprod;
  logic          big;
  logic [31:0]   u0_r;
  logic [5:0]    n0_r;
  logic          big0_r;
  logic [TW-1:0] tag0_r;

  assign n_full = w_i[W-1:32];
  assign big    = n_full > (W-32)'(32);
  assign fprod  = 64'(w_i[31:0]) * 64'(hdrtm_pkg::LN2_Q);

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r   <= fprod[63:32];
      n0_r   <= n_full[5:0];
      big0_r <= big;
      tag0_r <= tag_i;
    end
  end

  // series terms: multiply stage then constant divide stage
  logic [31:0]   p_r   [NS];
  logic [31:0]   ua_r  [NS];
  logic [32:0]   sa_r  [NS];
  logic [5:0]    na_r  [NS];
  logic          biga_r[NS];
  logic [TW-1:0] taga_r[NS];
  logic [31:0]   term_r[NS];
  logic [31:0]   ub_r  [NS];
  logic [32:0]   sb_r  [NS];
  logic [5:0]    nb_r  [NS];
  logic          bigb_r[NS];
  logic [TW-1:0] tagb_r[NS];

  for (genvar j = 0; j < NS; j++) begin : g_term
    localparam int K = j + 2;
    logic [31:0]   term_in;
    logic [31:0]   u_in;
    logic [32:0]   sum_in;
    logic [5:0]    n_in;
    logic          big_in;
    logic [TW-1:0] tag_in;
    logic [63:0]   mprod;
    logic [64:0]   qprod;
    logic [31:0]   q;

    if (j == 0) begin : g_first
      assign term_in = u0_r;
      assign u_in    = u0_r;
      assign sum_in  = (33'd1 << 32) - 33'(u0_r);
      assign n_in    = n0_r;
      assign big_in  = big0_r;
      assign tag_in  = tag0_r;
    end else begin : g_next
      assign term_in = term_r[j-1];
      assign u_in    = ub_r[j-1];
      assign sum_in  = sb_r[j-1];
      assign n_in    = nb_r[j-1];
      assign big_in  = bigb_r[j-1];
      assign tag_in  = tagb_r[j-1];
    end

    assign mprod = 64'(term_in) * 64'(u_in);
    assign qprod = 65'(p_r[j]) * 65'(hdrtm_pkg::DIV_M[K]);
    assign q     = 32'(qprod >> hdrtm_pkg::DIV_S[K]);

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[j]    <= mprod[63:32];
        ua_r[j]   <= u_in;
        sa_r[j]   <= sum_in;
        na_r[j]   <= n_in;
        biga_r[j] <= big_in;
        taga_r[j] <= tag_in;
        term_r[j] <= q;
        ub_r[j]   <= ua_r[j];
        sb_r[j]   <= (K % 2 == 1) ? sa_r[j] - 33'(q) : sa_r[j] + 33'(q);
        nb_r[j]   <= na_r[j];
        bigb_r[j] <= biga_r[j];
        tagb_r[j] <= taga_r[j];
      end
    end
  end

  // final scale by 2^-n
  always_ff @(posedge clk) begin
    if (en) begin
      res_o <= bigb_r[NS-1] ? 33'd0 : sb_r[NS-1] >> nb_r[NS-1];
      tag_o <= tagb_r[NS-1];
    end
  end

endmodule

### rtl/hdrtm_log2.sv
module hdrtm_log2 #(
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   v_i,
  input  logic [TW-1:0] tag_i,
  output logic [4:0]    k_o,
  output logic [31:0]   frac_o,
  output logic [TW-1:0] tag_o
);

  localparam int NB = hdrtm_pkg::FRAC_BITS;

  // normalize, coarse steps
  logic [31:0]   y16, y8;
  logic [31:0]   ya_r;
  logic [4:0]    ka_r;
  logic [TW-1:0] taga_r;

  assign y16 = (v_i[31:16] == 16'd0) ? {v_i[15:0], 16'd0} : v_i;
  assign y8  = (y16[31:24] == 8'd0) ? {y16[23:0], 8'd0} : y16;

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r   <= y8;
      ka_r   <= {v_i[31:16] == 16'd0, y16[31:24] == 8'd0, 3'd0};
      taga_r <= tag_i;
    end
  end

  // normalize, fine steps
  logic [31:0]   y4, y2, y1;
  logic [31:0]   yb_r;
  logic [4:0]    kb_r;
  logic [TW-1:0] tagb_r;

  assign y4 = (ya_r[31:28] == 4'd0) ? {ya_r[27:0], 4'd0} : ya_r;
  assign y2 = (y4[31:30] == 2'd0) ? {y4[29:0], 2'd0} : y4;
  assign y1 = (y2[31] == 1'b0) ? {y2[30:0], 1'b0} : y2;

  always_ff @(posedge clk) begin
    if (en) begin
      yb_r   <= y1;
      kb_r   <= {ka_r[4:3], ya_r[31:28] == 4'd0, y4[31:30] == 2'd0, y2[31] == 1'b0};
      tagb_r <= taga_r;
    end
  end

  // one fraction bit per squaring stage
  logic [31:0]   ys_r [NB];
  logic [31:0]   fs_r [NB];
  logic [4:0]    ks_r [NB];
  logic [TW-1:0] ts_r [NB];

  for (genvar i = 0; i < NB; i++) begin : g_sq
    logic [31:0]   y_in;
    logic [31:0]   f_in;
    logic [4:0]    k_in;
    logic [TW-1:0] t_in;
    logic [63:0]   sq;
    logic [32:0]   sq_s;

    if (i == 0) begin : g_first
      assign y_in = yb_r;
      assign f_in = 32'd0;
      assign k_in = kb_r;
      assign t_in = tagb_r;
    end else begin : g_next
      assign y_in = ys_r[i-1];
      assign f_in = fs_r[i-1];
      assign k_in = ks_r[i-1];
      assign t_in = ts_r[i-1];
    end

    assign sq   = 64'(y_in) * 64'(y_in);
    assign sq_s = sq[63:31];

    always_ff @(posedge clk) begin
      if (en) begin
        ys_r[i] <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
        fs_r[i] <= {f_in[30:0], sq_s[32]};
        ks_r[i] <= k_in;
        ts_r[i] <= t_in;
      end
    end
  end

  assign k_o    = ks_r[NB-1];
  assign frac_o = fs_r[NB-1];
  assign tag_o  = ts_r[NB-1];

endmodule

### rtl/hdrtm_lane.sv
module hdrtm_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] exposure_gain,
  input  logic [15:0] gamma_exponent,
  input  logic [15:0] half_i,
  output logic [7:0]  byte_o
);

  // decode and exposure product
  logic [4:0]  e_raw;
  logic [10:0] mant;
  logic [26:0] t0_r;
  logic [4:0]  e1_r;
  logic        kill1_r;

  assign e_raw = half_i[14:10];
  assign mant  = (e_raw == 5'd0) ? {1'b0, half_i[9:0]} : {1'b1, half_i[9:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r    <= 27'(mant) * 27'(exposure_gain);
      e1_r    <= (e_raw == 5'd0) ? 5'd1 : e_raw;
      kill1_r <= half_i[15] | (e_raw == 5'd31);
    end
  end

  // exponent alignment and overflow cap
  logic [51:0] tsh;
  logic [36:0] t2_r;
  logic        cap2_r;
  logic        kill2_r;

  always_comb begin
    if (e1_r >= 5'd5) begin
      tsh = 52'(t0_r) << (e1_r - 5'd5);
    end else begin
      tsh = 52'(t0_r >> (5'd5 - e1_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r    <= tsh[36:0];
      cap2_r  <= |tsh[51:37];
      kill2_r <= kill1_r;
    end
  end

  // scale by log2(e), low partial product
  logic [62:0] pl_r;
  logic [4:0]  th_r;
  logic [31:0] tl_r;
  logic        cap3_r;
  logic        kill3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r    <= 63'(t2_r[31:0]) * 63'(hdrtm_pkg::LOG2E_LO);
      th_r    <= t2_r[36:32];
      tl_r    <= t2_r[31:0];
      cap3_r  <= cap2_r;
      kill3_r <= kill2_r;
    end
  end

  // combine partial products
  logic [37:0] w4_r;
  logic        cap4_r;
  logic        kill4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w4_r    <= {1'b0, th_r, 32'd0} + 38'(36'(th_r) * 36'(hdrtm_pkg::LOG2E_LO))
                 + 38'(tl_r) + 38'(pl_r[62:32]);
      cap4_r  <= cap3_r;
      kill4_r <= kill3_r;
    end
  end

  // exp(-t)
  logic [32:0] e_val;
  logic [1:0]  e_tag;

  hdrtm_pow2 #(.W(38), .TW(2)) u_exp (
    .clk   (clk),
    .en    (en),
    .w_i   (w4_r),
    .tag_i ({cap4_r, kill4_r}),
    .res_o (e_val),
    .tag_o (e_tag)
  );

  // tone curve and result mode
  logic [32:0]           v_full;
  hdrtm_pkg::r_mode_t    mode5;
  logic [31:0]           v5_r;
  hdrtm_pkg::r_mode_t    mode5_r;

  assign v_full = (33'd1 << 32) - e_val;

  always_comb begin
    priority if (e_tag[0]) begin
      mode5 = hdrtm_pkg::MODE_ZERO;
    end else if (e_tag[1]) begin
      mode5 = hdrtm_pkg::MODE_ONE;
    end else if (v_full == 33'd0) begin
      mode5 = hdrtm_pkg::MODE_ZERO;
    end else if (v_full[32]) begin
      mode5 = hdrtm_pkg::MODE_ONE;
    end else begin
      mode5 = hdrtm_pkg::MODE_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v5_r    <= v_full[31:0];
      mode5_r <= mode5;
    end
  end

  // -log2(v)
  logic [4:0]  lk;
  logic [31:0] lfrac;
  logic [1:0]  l_tag;

  hdrtm_log2 #(.TW(2)) u_log (
    .clk    (clk),
    .en     (en),
    .v_i    (v5_r),
    .tag_i  (mode5_r),
    .k_o    (lk),
    .frac_o (lfrac),
    .tag_o  (l_tag)
  );

  // assemble log value, then scale by gamma
  logic [37:0] l6_r;
  logic [1:0]  mode6_r;
  logic [53:0] gprod;
  logic [39:0] w7_r;
  logic [1:0]  mode7_r;

  assign gprod = 54'(l6_r) * 54'(gamma_exponent);

  always_ff @(posedge clk) begin
    if (en) begin
      l6_r    <= {6'(lk) + 6'd1, 32'd0} - 38'(lfrac);
      mode6_r <= l_tag;
      w7_r    <= gprod[53:14];
      mode7_r <= mode6_r;
    end
  end

  // 2^-(gamma * log)
  logic [32:0] r_val;
  logic [1:0]  r_tag;

  hdrtm_pow2 #(.W(40), .TW(2)) u_pow (
    .clk   (clk),
    .en    (en),
    .w_i   (w7_r),
    .tag_i (mode7_r),
    .res_o (r_val),
    .tag_o (r_tag)
  );

  // byte scaling
  logic [32:0] r_sel;
  logic [40:0] r255;

  always_comb begin
    unique case (hdrtm_pkg::r_mode_t'(r_tag))
      hdrtm_pkg::MODE_ZERO: r_sel = 33'd0;
      hdrtm_pkg::MODE_ONE:  r_sel = 33'd1 << 32;
      hdrtm_pkg::MODE_CALC: r_sel = r_val;
      default:              r_sel = 33'd0;
    endcase
  end

  assign r255 = {r_sel, 8'd0} - 41'(r_sel);

  always_ff @(posedge clk) begin
    if (en) begin
      byte_o <= r255[39:32];
    end
  end

endmodule

### rtl/half_float_hdr_tonemap_pixel_top.sv
// channel   | dir | handshake     | payload
// in_pix    | in  | valid / ready | red_half, green_half, blue_half (binary16)
// out_pix   | out | valid / ready | out_blue, out_green, out_red, out_alpha
// cfg       | in  | cfg_wr_en     | cfg_index, cfg_wdata (no read-back)
//
// one pixel per clock while the pipeline advances; the latency is set by the two
// exponent series pipelines and the 32-stage squaring log in each channel lane.
// rst_n is synchronous, active low; it clears the valid chain and loads the
// register defaults. the whole pipeline advances only while the output register
// is empty or being taken, so in_pix.ready follows out_pix.ready.
module half_float_hdr_tonemap_pixel_top (
  input  logic                  clk,
  input  logic                  rst_n,
  hdrtm_pix_in_if.sink          in_pix,
  hdrtm_pix_out_if.source       out_pix,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);

  localparam int LAT = hdrtm_pkg::LANE_LAT;

  // configuration registers
  logic [15:0] exposure_r;
  logic [15:0] gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r <= hdrtm_pkg::EXPOSURE_RST;
      gamma_r    <= hdrtm_pkg::GAMMA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hdrtm_pkg::CFG_EXPOSURE: exposure_r <= cfg_wdata;
        hdrtm_pkg::CFG_GAMMA:    gamma_r    <= cfg_wdata;
        default:                 ;
      endcase
    end
  end

  // pipeline advance and transaction tracking
  logic           en;
  logic           in_fire;
  logic [LAT-1:0] vld_r;
  logic           out_valid_r;

  assign en           = !out_valid_r || out_pix.ready;
  assign in_pix.ready = en;
  assign in_fire      = in_pix.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_fire};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // one lane per color channel
  logic [7:0] blue_b, green_b, red_b;

  hdrtm_lane u_lane_blue (
    .clk            (clk),
    .en             (en),
    .exposure_gain  (exposure_r),
    .gamma_exponent (gamma_r),
    .half_i         (in_pix.blue_half),
    .byte_o         (blue_b)
  );

  hdrtm_lane u_lane_green (
    .clk            (clk),
    .en             (en),
    .exposure_gain  (exposure_r),
    .gamma_exponent (gamma_r),
    .half_i         (in_pix.green_half),
    .byte_o         (green_b)
  );

  hdrtm_lane u_lane_red (
    .clk            (clk),
    .en             (en),
    .exposure_gain  (exposure_r),
    .gamma_exponent (gamma_r),
    .half_i         (in_pix.red_half),
    .byte_o         (red_b)
  );

  // merge lanes into the bgr output register; alpha is the opaque constant
  logic [7:0] blue_r, green_r, red_r;

  always_ff @(posedge clk) begin
    if (en) begin
      blue_r  <= blue_b;
      green_r <= green_b;
      red_r   <= red_b;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.out_blue  = blue_r;
  assign out_pix.out_green = green_r;
  assign out_pix.out_red   = red_r;
  assign out_pix.out_alpha = hdrtm_pkg::ALPHA_OPAQUE;

endmodule

### verif/tb_half_float_hdr_tonemap_pixel_top.sv
`timescale 1ns / 1ps

module tb_half_float_hdr_tonemap_pixel_top;

  typedef logic [63:0] q64_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  typedef struct {
    logic [15:0] red_h;
    logic [15:0] green_h;
    logic [15:0] blue_h;
    bit          fixed_known;
    bgr_t        fixed_bytes;
  } pix_row_t;

  localparam q64_t ONE_Q     = 64'd1 << 32;
  localparam q64_t LOG2E_Q   = 64'h1_7154_7652;
  localparam int   CYCLE_CAP = 400000;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [0:0] cfg_index;
  logic [15:0] cfg_wdata;

  hdrtm_pix_in_if  in_pix();
  hdrtm_pix_out_if out_pix();

  half_float_hdr_tonemap_pixel_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix.sink),
    .out_pix  (out_pix.source),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the registers
  logic [15:0] model_exposure;
  logic [15:0] model_gamma;

  bgr_t pending_pixels[$];
  int   mismatch_count;
  int   pixels_checked;
  int   cycle_count;
  bit   no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exp(-u) series, u in [0, ln2)
  function automatic q64_t exp_series(q64_t u);
    q64_t sum;
    q64_t term;
    sum = ONE_Q;
    term = ONE_Q;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * u) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // 2^-w for Q.32 w
  function automatic q64_t pow2_neg_q(q64_t w);
    q64_t u;
    if ((w >> 32) > 32) return 64'd0;
    u = ((w & 64'hFFFF_FFFF) * {32'd0, hdrtm_pkg::LN2_Q}) >> 32;
    return exp_series(u) >> (w >> 32);
  endfunction

  // -log2 of a Q.32 value below one, by repeated squaring
  function automatic q64_t neg_log2_q(q64_t v);
    q64_t shift_cnt;
    q64_t y;
    q64_t bits;
    shift_cnt = 0;
    bits = 0;
    while (v < (64'd1 << 31)) begin
      v = v << 1;
      shift_cnt++;
    end
    y = v;
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      bits = bits << 1;
      if (y >= (64'd1 << 32)) begin
        bits = bits | 64'd1;
        y = y >> 1;
      end
    end
    return ((shift_cnt + 1) << 32) - bits;
  endfunction

  // one channel: decode, tone curve, gamma, byte
  function automatic logic [7:0] tone_byte(logic [15:0] h);
    q64_t e;
    q64_t m;
    q64_t t;
    q64_t e_neg;
    q64_t v;
    q64_t r;
    q64_t b;
    logic [127:0] wide;
    e = q64_t'(h[14:10]);
    m = q64_t'(h[9:0]);
    if (h[15] || e == 31) return 8'd0;
    if (e == 0) e = 1;
    else m = m | 64'h400;
    t = m * q64_t'(model_exposure);
    if (e >= 5) t = t << (e - 5);
    else t = t >> (5 - e);
    if (t >= (64'd32 << 32)) begin
      e_neg = 0;
    end else begin
      wide = (128'(t) * 128'(LOG2E_Q)) >> 32;
      e_neg = pow2_neg_q(wide[63:0]);
    end
    v = ONE_Q - e_neg;
    if (v == 0) return 8'd0;
    if (v >= ONE_Q) r = ONE_Q;
    else r = pow2_neg_q((neg_log2_q(v) * q64_t'(model_gamma)) >> 14);
    b = (r * 255) >> 32;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic bgr_t tone_map_pixel(logic [15:0] rh, logic [15:0] gh, logic [15:0] bh);
    bgr_t p;
    p.blue = tone_byte(bh);
    p.green = tone_byte(gh);
    p.red = tone_byte(rh);
    return p;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (pixel %0d)", what, got, want, pixels_checked);
    mismatch_count++;
  endtask

  // output side: random backpressure and result check
  always @(posedge clk) begin
    bgr_t want;
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
    end else begin
      if (out_pix.valid && out_pix.ready) begin
        if (pending_pixels.size() == 0) begin
          note_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_pix.out_blue !== want.blue) note_mismatch("blue", out_pix.out_blue, want.blue);
          if (out_pix.out_green !== want.green)
            note_mismatch("green", out_pix.out_green, want.green);
          if (out_pix.out_red !== want.red) note_mismatch("red", out_pix.out_red, want.red);
          if (out_pix.out_alpha !== hdrtm_pkg::ALPHA_OPAQUE)
            note_mismatch("alpha", out_pix.out_alpha, hdrtm_pkg::ALPHA_OPAQUE);
        end
        pixels_checked++;
      end
      out_pix.ready <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // one pixel transaction, sometimes followed by a random gap
  task automatic send_pixel(logic [15:0] rh, logic [15:0] gh, logic [15:0] bh, output bgr_t got);
    in_pix.valid <= 1'b1;
    in_pix.red_half <= rh;
    in_pix.green_half <= gh;
    in_pix.blue_half <= bh;
    do @(posedge clk); while (!in_pix.ready);
    got = tone_map_pixel(rh, gh, bh);
    pending_pixels.push_back(got);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_pix.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // both registers, back to back
  task automatic write_regs(logic [15:0] exposure, logic [15:0] gamma_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= hdrtm_pkg::CFG_EXPOSURE;
    cfg_wdata <= exposure;
    @(posedge clk);
    cfg_index <= hdrtm_pkg::CFG_GAMMA;
    cfg_wdata <= gamma_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_exposure = exposure;
    model_gamma = gamma_val;
  endtask

  // mostly plausible positive values, some raw patterns
  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    if ($urandom_range(99) < 65) begin
      h[15] = 1'b0;
      h[14:10] = 5'($urandom_range(0, 19));
    end
    return h;
  endfunction

  pix_row_t directed_rows[$];

  initial begin
    bgr_t got;
    logic [15:0] exposure_set[8];
    logic [15:0] gamma_set[8];
    in_pix.valid = 1'b0;
    in_pix.red_half = '0;
    in_pix.green_half = '0;
    in_pix.blue_half = '0;
    out_pix.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = hdrtm_pkg::CFG_EXPOSURE;
    cfg_wdata = '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    pixels_checked = 0;
    cycle_count = 0;
    model_exposure = hdrtm_pkg::EXPOSURE_RST;
    model_gamma = hdrtm_pkg::GAMMA_RST;

    // reset
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: known bytes where obvious, predictor elsewhere
    directed_rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{16'h7BFF, 16'h7BFF, 16'h7BFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{16'h7BFF, 16'h0000, 16'h8000, 1'b1, '{8'd0, 8'd0, 8'd255}},
      '{16'h7C00, 16'hFC00, 16'h7E00, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{16'hFFFF, 16'h7FFF, 16'hBC00, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{16'h0001, 16'h03FF, 16'h0400, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{16'h3C00, 16'h3800, 16'h4000, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{16'h2E66, 16'h4900, 16'h1400, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{16'h5555, 16'h2AAA, 16'h3FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{16'h0200, 16'h0155, 16'h02AA, 1'b0, '{8'd0, 8'd0, 8'd0}}
    };
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].red_h, directed_rows[i].green_h, directed_rows[i].blue_h, got);
      if (directed_rows[i].fixed_known && got != directed_rows[i].fixed_bytes)
        note_mismatch("directed row predictor", i, -1);
    end
    in_pix.valid <= 1'b0;
    wait_drained();

    // register settings per phase, extremes and out-of-range gamma included
    exposure_set = '{hdrtm_pkg::EXPOSURE_RST, 16'd0, 16'hFFFF, 16'd1, 16'd4096,
                     hdrtm_pkg::EXPOSURE_RST, 16'($urandom), 16'($urandom)};
    gamma_set = '{hdrtm_pkg::GAMMA_RST, hdrtm_pkg::GAMMA_RST, 16'hFFFF, 16'd1, 16'd16384,
                  16'd0, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
    for (int ph = 0; ph < 8; ph++) begin
      @(posedge clk);
      write_regs(exposure_set[ph], gamma_set[ph]);
      for (int n = 0; n < 200; n++) begin
        no_idle = (ph == 3) || (ph == 6 && n < 100);
        send_pixel(rand_half(), rand_half(), rand_half(), got);
      end
      in_pix.valid <= 1'b0;
      no_idle = 1'b0;
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("checked %0d pixels over 8 register settings plus a directed set", pixels_checked);
    $display("stalls on both sides, gamma zero and exposure extremes included");
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d pixels outstanding", mismatch_count, pending_pixels.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### half_float_hdr_tonemap_pixel_top.f
rtl/hdrtm_pkg.sv
rtl/hdrtm_pix_in_if.sv
rtl/hdrtm_pix_out_if.sv
rtl/hdrtm_pow2.sv
rtl/hdrtm_log2.sv
rtl/hdrtm_lane.sv
rtl/half_float_hdr_tonemap_pixel_top.sv
verif/tb_half_float_hdr_tonemap_pixel_top.sv
